// ===== src/bounded_integer_set_table_macros.svh =====
// ----------------------------------------------------------------------------
// Bounded integer set table assertion macros
// Shared concurrent assertion shorthands for the set table RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_TABLE_MACROS_SVH
`define BOUNDED_INTEGER_SET_TABLE_MACROS_SVH

`ifndef SYNTH
// condition must hold at every edge out of reset
`define BIST_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("set table check failed");
// antecedent implies consequent in the same cycle
`define BIST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("set table check failed");
// antecedent implies consequent in the next cycle
`define BIST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("set table check failed");
`else
`define BIST_ASSERT_ALWAYS(label, clk, rst, cond)
`define BIST_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BIST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/bist_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded integer set table package
// Operation and status codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bist_pkg;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 7;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                      insert_en;
      logic                      remove_en;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== src/bist_cell.sv =====
// ----------------------------------------------------------------------------
// Set table cell
// Holds one table entry, compares it against the request value and shifts
// down from its upper neighbor when an entry at or below it is removed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bist_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  wire logic                              clock,
   input  wire bist_pkg::cell_ctl_type            ctl,
   input  wire logic [CNT_W-1:0]                  count,
   input  wire logic signed [bist_pkg::VALUE_W-1:0] upper_entry,
   input  wire logic                              hit_in,
   input  wire logic [CNT_W-1:0]                  pos_in,
   output logic signed [bist_pkg::VALUE_W-1:0]    entry,
   output logic                                   match,
   output logic                                   hit_out,
   output logic [CNT_W-1:0]                       pos_out
);
   import bist_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      occupied;

   assign occupied = CNT_W'(IDX) < count;
   assign match    = occupied && (entry_ff == ctl.value);
   assign hit_out  = hit_in | match;
   assign pos_out  = match ? CNT_W'(IDX + 1) : pos_in;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      // append lands in the first free slot
      if (ctl.insert_en && (count == CNT_W'(IDX))) begin
         entry_in = ctl.value;
      end
      // close the gap: pull from the neighbor above
      if (ctl.remove_en && hit_out) begin
         entry_in = upper_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== src/bounded_integer_set_table.sv =====
// ----------------------------------------------------------------------------
// Bounded integer set table
// Packed table of distinct signed 32-bit values with insert, remove and query.
//
// Channels: req_* carries one item per operation (func on req_tuser, value on
//   req_tdata); rsp_* returns exactly one item per request (status on
//   rsp_tuser, position and element count on rsp_tdata).
// Structure: a row of CAPACITY cells. Each cell compares its entry with the
//   request value; hit and position ride a ripple chain from cell 0 upward,
//   and on remove every cell at or above the match pulls its upper neighbor.
// Sequence: an accepted item is captured, then executed in S_EXEC, which loads
//   the response register; req_tready stays low until the controller is idle again.
// Stall: the response register holds until rsp_tready. One more request may
//   still be captured meanwhile; its execute step then waits with req_tready
//   low until the register drains, so nothing is lost or overwritten.
// Reset: clear the element count and all handshake state; entry contents
//   stay undefined since only entries below the count are ever compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_integer_set_table_macros.svh"

module bounded_integer_set_table #(
   parameter int CAPACITY = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [6:0] position, [13:7] count, [15:14] zero
   output logic [1:0]       rsp_tuser    // [1:0] status
);
   import bist_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // controller
   state_type state_ff, state_in;
   logic      req_accept;
   logic      rsp_accept;
   logic      slot_free;
   logic      commit;

   // captured request
   logic [FUNC_W-1:0]         func_ff;
   logic signed [VALUE_W-1:0] value_ff;

   // table state
   logic [CNT_W-1:0] count_ff, count_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    cnt_out_ff, cnt_out_in;

   // cell row
   cell_ctl_type              ctl;
   logic signed [VALUE_W-1:0] entry_vec [CAPACITY+1];
   logic                      hit_chain [CAPACITY+1];
   logic [CNT_W-1:0]          pos_chain [CAPACITY+1];
   logic [CAPACITY-1:0]       match_vec;
   logic                      hit;
   logic [CNT_W-1:0]          pos_found;
   logic [CNT_W+POS_W-1:0]    pos_wide;
   logic [CNT_W+POS_W-1:0]    cnt_wide;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == S_EXEC) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_EXEC:  req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   // the cell row: entry of the top cell's upper neighbor is a dummy zero
   assign entry_vec[CAPACITY] = '0;
   assign hit_chain[0]        = 1'b0;
   assign pos_chain[0]        = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bist_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .upper_entry (entry_vec[i+1]),
         .hit_in      (hit_chain[i]),
         .pos_in      (pos_chain[i]),
         .entry       (entry_vec[i]),
         .match       (match_vec[i]),
         .hit_out     (hit_chain[i+1]),
         .pos_out     (pos_chain[i+1])
      );
   end

   assign hit       = hit_chain[CAPACITY];
   assign pos_found = pos_chain[CAPACITY];

   // decide the operation outcome in the execute cycle
   always_comb begin
      ctl.insert_en = 1'b0;
      ctl.remove_en = 1'b0;
      ctl.value     = value_ff;
      status_in     = ST_MISS;
      pos_wide      = '0;
      count_in      = count_ff;
      unique case (func_ff)
         FUNC_INSERT: begin
            // duplicate check takes precedence over full
            if (hit) begin
               status_in = ST_MISS;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               status_in     = ST_OK;
               ctl.insert_en = commit;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE: begin
            if (hit) begin
               status_in     = ST_OK;
               ctl.remove_en = commit;
               count_in      = count_ff - CNT_W'(1);
            end
         end
         FUNC_QUERY: begin
            if (hit) begin
               status_in = ST_OK;
               pos_wide  = {{POS_W{1'b0}}, pos_found};
            end
         end
         default: status_in = ST_MISS;
      endcase
   end

   // position and count wrap to the 7-bit field
   assign cnt_wide   = {{POS_W{1'b0}}, count_in};
   assign pos_in     = pos_wide[POS_W-1:0];
   assign cnt_out_in = cnt_wide[POS_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   // payload: hold the request, load the response on commit
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff  <= req_tuser;
         value_ff <= req_tdata;
      end
      if (commit) begin
         status_ff  <= status_in;
         pos_ff     <= pos_in;
         cnt_out_ff <= cnt_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00, cnt_out_ff, pos_ff};

   // table never overfills
   `BIST_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   // entries are distinct, so at most one cell matches
   `BIST_ASSERT_IMPLIES(a_match_onehot, clock, reset, state_ff == S_EXEC,
      $onehot0(match_vec))
   // an accepted item goes straight to execute
   `BIST_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == S_EXEC)
   // a committed insert grows the table by one
   `BIST_ASSERT_NEXT(a_insert_grows, clock, reset, ctl.insert_en,
      count_ff == $past(count_ff) + CNT_W'(1))
   // full is only reported against a full table
   `BIST_ASSERT_IMPLIES(a_full_status, clock, reset, rsp_valid_ff && status_ff == ST_FULL,
      count_ff == CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ===== tb/bounded_integer_set_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer set table testbench
// Streams insert, remove, query and unused-code requests into the set table.
// A local copy of the table predicts every response, and each response is
// checked field by field in arrival order. Requests come in bursts with
// random gaps. The response side stalls on its own schedule.
// ----------------------------------------------------------------------------

module bounded_integer_set_table_test;

   import bist_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int FILL_SPAN   = 70;      // distinct values per fill run, above capacity
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 16;
   localparam int SHOW_LIMIT  = 10;

   // code the block leaves unused; it must report a miss and change nothing
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
   } set_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [POS_W-1:0]    count;
   } set_result_type;

   // ---------------------------------------------------------------- DUT ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [31:0] value
   logic [1:0]  req_tuser  = '0;    // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [6:0] position, [13:7] count, [15:14] zero
   logic [1:0]  rsp_tuser;          // [1:0] status

   bounded_integer_set_table #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow table
   logic [VALUE_W-1:0] held_values [CAPACITY];
   int                 held_count = 0;
   int                 peak_count = 0;

   set_request_type request_queue[$];
   set_result_type  expected_results[$];

   int fault_count = 0;
   int func_tally[4];
   int status_tally[4];
   int result_count = 0;

   // Apply one request to the shadow table and return the response it must cause.
   function automatic set_result_type predict_set_op(logic [FUNC_W-1:0] func,
                                                     logic [VALUE_W-1:0] value);
      set_result_type r;
      int             hit;
      r.status   = ST_MISS;
      r.position = '0;
      hit        = -1;
      // first match only; entries above held_count are stale and never looked at
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_values[i] == value) hit = i;
      end
      case (func)
         FUNC_INSERT: begin
            // duplicate check wins over the full check
            if (hit >= 0) begin
               r.status = ST_MISS;
            end else if (held_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               held_values[held_count] = value;
               held_count++;
               r.status = ST_OK;
            end
         end
         FUNC_REMOVE: begin
            if (hit >= 0) begin
               // close the gap: everything above the match moves down one slot
               for (int j = hit; j < held_count - 1; j++) held_values[j] = held_values[j + 1];
               held_count--;
               r.status = ST_OK;
            end
         end
         FUNC_QUERY: begin
            if (hit >= 0) begin
               r.status   = ST_OK;
               r.position = POS_W'(hit + 1);
            end
         end
         default: ;
      endcase
      if (held_count > peak_count) peak_count = held_count;
      r.count = POS_W'(held_count);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus
   logic [VALUE_W-1:0] value_pool [96];

   task automatic push_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
      set_request_type item;
      item.func  = func;
      item.value = value;
      request_queue.push_back(item);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, 95)];
      return VALUE_W'($urandom);
   endfunction

   // Push the table to full with fresh values, poke it while full, then remove
   // every fresh value in a scrambled order so removes land at all positions.
   task automatic fill_and_drain();
      logic [VALUE_W-1:0] fresh [FILL_SPAN];
      int                 order [FILL_SPAN];
      logic               dup;
      int                 k;
      int                 tmp;
      for (int i = 0; i < FILL_SPAN; i++) begin
         do begin
            fresh[i] = VALUE_W'($urandom);
            dup = 1'b0;
            for (int j = 0; j < i; j++) if (fresh[j] == fresh[i]) dup = 1'b1;
         end while (dup);
         push_request(FUNC_INSERT, fresh[i]);
         order[i] = i;
      end
      push_request(FUNC_QUERY, fresh[CAPACITY - 1]);
      push_request(FUNC_INSERT, fresh[$urandom_range(0, FILL_SPAN - 1)]);
      push_request(FUNC_INSERT, VALUE_W'($urandom));
      push_request(FUNC_QUERY, fresh[$urandom_range(0, FILL_SPAN - 1)]);
      for (int i = FILL_SPAN - 1; i > 0; i--) begin
         k        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[k];
         order[k] = tmp;
      end
      for (int i = 0; i < FILL_SPAN; i++) begin
         push_request(FUNC_REMOVE, fresh[order[i]]);
         if (i % 8 == 7) push_request(FUNC_QUERY, fresh[$urandom_range(0, FILL_SPAN - 1)]);
      end
   endtask

   // One stretch of random traffic; kind biases it toward growing, shrinking or neither.
   task automatic random_episode(int kind, int length);
      int roll;
      int ins_cut;
      int rem_cut;
      ins_cut = (kind == 0) ? 70 : (kind == 1) ? 15 : 35;
      rem_cut = (kind == 0) ? 80 : (kind == 1) ? 70 : 65;
      for (int i = 0; i < length; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < ins_cut)      push_request(FUNC_INSERT, pick_value());
         else if (roll < rem_cut) push_request(FUNC_REMOVE, pick_value());
         else if (roll < 95)      push_request(FUNC_QUERY, pick_value());
         else                     push_request(FUNC_UNUSED, VALUE_W'($urandom));
      end
   endtask

   task automatic build_stimulus();
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 96; i++) value_pool[i] = VALUE_W'($urandom);

      // directed: empty table, extremes, duplicates, shifts at both ends, unused code
      push_request(FUNC_QUERY,  32'd5);
      push_request(FUNC_REMOVE, 32'd5);
      push_request(FUNC_INSERT, 32'h7FFF_FFFF);
      push_request(FUNC_INSERT, 32'h8000_0000);
      push_request(FUNC_INSERT, 32'h0000_0000);
      push_request(FUNC_INSERT, 32'hFFFF_FFFF);
      push_request(FUNC_INSERT, 32'h7FFF_FFFF);
      push_request(FUNC_QUERY,  32'h8000_0000);
      push_request(FUNC_QUERY,  32'hFFFF_FFFF);
      push_request(FUNC_QUERY,  32'h0000_0001);
      push_request(FUNC_UNUSED, 32'h0000_0000);
      push_request(FUNC_UNUSED, 32'hFFFF_FFFF);
      push_request(FUNC_REMOVE, 32'h8000_0000);
      push_request(FUNC_QUERY,  32'h0000_0000);
      push_request(FUNC_QUERY,  32'hFFFF_FFFF);
      push_request(FUNC_REMOVE, 32'hFFFF_FFFF);
      push_request(FUNC_REMOVE, 32'h7FFF_FFFF);
      push_request(FUNC_REMOVE, 32'h7FFF_FFFF);
      push_request(FUNC_QUERY,  32'h0000_0000);
      push_request(FUNC_REMOVE, 32'h0000_0000);
      push_request(FUNC_INSERT, 32'h5555_5555);
      push_request(FUNC_INSERT, 32'hAAAA_AAAA);
      push_request(FUNC_QUERY,  32'hAAAA_AAAA);
      push_request(FUNC_REMOVE, 32'h5555_5555);
      push_request(FUNC_REMOVE, 32'hAAAA_AAAA);

      // random: start from an empty table so the first fill reaches position 64
      fill_and_drain();
      while (request_queue.size() < 700) random_episode($urandom_range(0, 2), 40);
      fill_and_drain();
   endtask

   // ---------------------------------------------------------------- request driver
   set_request_type active_item;
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_set_op(active_item.func, active_item.value));
            func_tally[active_item.func]++;
         end
         // advance only once the bus is free; hold the item otherwise
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               active_item = request_queue.pop_front();
               req_tuser  <= active_item.func;
               req_tdata  <= active_item.value;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  // sometimes a long unbroken stretch, usually a short burst
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- response sink
   // Alternate between free-running windows and windows with random stalls.
   int  sink_phase_cycles = 0;
   logic sink_free        = 1'b0;
   int  sink_hold_left    = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         sink_phase_cycles++;
         if (sink_phase_cycles >= 300) begin
            sink_phase_cycles = 0;
            sink_free         = !sink_free;
         end
         if (sink_free) begin
            rsp_tready <= 1'b1;
         end else if (sink_hold_left > 0) begin
            sink_hold_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            sink_hold_left = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- response checker
   task automatic report_fault(string what, int unsigned want, int unsigned got);
      fault_count++;
      if (fault_count <= SHOW_LIMIT)
         $display("[%0t] response %0d: %s expected %0d, got %0d",
                  $time, result_count, what, want, got);
   endtask

   always @(posedge clock) begin
      set_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT)
               $display("[%0t] response with nothing outstanding: tuser %0d tdata %h",
                        $time, rsp_tuser, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser != want.status)
               report_fault("status", want.status, rsp_tuser);
            if (rsp_tdata[6:0] != want.position)
               report_fault("position", want.position, rsp_tdata[6:0]);
            if (rsp_tdata[13:7] != want.count)
               report_fault("count", want.count, rsp_tdata[13:7]);
            status_tally[want.status]++;
         end
         result_count++;
      end
   end

   // ---------------------------------------------------------------- watchdog
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // wait for every request to go in and every response to come back
      while (request_queue.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Ran %0d requests: %0d insert, %0d remove, %0d query, %0d unused code",
               result_count, func_tally[0], func_tally[1], func_tally[2], func_tally[3]);
      $display("Responses ok/miss/full = %0d/%0d/%0d, peak fill %0d of %0d, %0d mismatches",
               status_tally[0], status_tally[1], status_tally[2], peak_count, CAPACITY,
               fault_count);
      if (fault_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
